>>> rtl/core/tpcp_pkg.sv
package tpcp_pkg;

  // Fixed field widths
  localparam int COUNT_W = 16;
  localparam int DEAD_W  = 9;
  localparam int NPHASE  = 3;

  // Permille scaling: product of period and clamped duty, then divide by 1000
  localparam int                 PERMILLE_W   = 10;
  localparam logic [PERMILLE_W-1:0] PERMILLE_MAX = 10'd1000;
  localparam int                 SCALED_W     = COUNT_W + PERMILLE_W;
  // floor(x / 1000) = (x * ceil(2^36 / 1000)) >> 36, exact for x < 2^26
  localparam int                 RECIP_SHIFT  = 36;
  localparam int                 RECIP_W      = 27;
  localparam logic [RECIP_W-1:0] RECIP_1000   = 27'd68719477;
  localparam int                 RPROD_W      = SCALED_W + RECIP_W;

  // Transaction queue between front and back
  localparam int Q_DEPTH = 8;
  localparam int Q_AW    = 3;
  localparam int Q_CW    = 4;

  // Configuration register indexes
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_PERIOD   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_CMP  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DEAD_RISE = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DEAD_FALL = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ADC_POINT = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_PERMILLE  = 3'd5;
  localparam int CFG_DATA_W = 16;

  // Reset values of the registers
  localparam logic [COUNT_W-1:0] PERIOD_RESET  = 16'd1000;
  localparam logic [COUNT_W-1:0] MIN_CMP_RESET = 16'd3;
  localparam logic [COUNT_W-1:0] ADC_RESET     = 16'd900;

  typedef struct packed {
    logic [COUNT_W-1:0] period_counts;
    logic [COUNT_W-1:0] min_compare;
    logic [DEAD_W-1:0]  dead_rise;
    logic [DEAD_W-1:0]  dead_fall;
    logic [COUNT_W-1:0] adc_point;
    logic               permille_mode;
  } cfg_t;

  // One compare pair; cb may reach one past the count range
  typedef struct packed {
    logic               zero;
    logic [COUNT_W-1:0] ca;
    logic [COUNT_W:0]   cb;
  } edge_t;

  localparam logic [COUNT_W-1:0] RESET_CENTRE = PERIOD_RESET >> 1;
  localparam edge_t RESET_EDGE = '{zero: 1'b1, ca: RESET_CENTRE,
                                   cb: {1'b0, RESET_CENTRE} + 17'd1};

  typedef struct packed {
    logic [COUNT_W-1:0] duty_u;
    logic [COUNT_W-1:0] duty_v;
    logic [COUNT_W-1:0] duty_w;
    logic               duty_write;
    logic               outputs_enable;
    logic               gate_enable;
  } in_item_t;

  typedef struct packed {
    logic               u_low_gate;
    logic               u_high_gate;
    logic               v_low_gate;
    logic               v_high_gate;
    logic               w_low_gate;
    logic               w_high_gate;
    logic               driver_enable;
    logic               adc_trigger;
    logic               period_event;
    logic [COUNT_W-1:0] count_now;
  } out_item_t;

  // Per-tick controls carried along the front pipeline
  typedef struct packed {
    logic duty_write;
    logic outputs_enable;
    logic gate_enable;
  } ctl_t;

  // Classified tick handed from front to back
  typedef struct packed {
    ctl_t                    ctl;
    edge_t [NPHASE-1:0]      edges;
  } q_item_t;

endpackage

>>> rtl/core/tpcp_front.sv
module tpcp_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  tpcp_pkg::in_item_t in_data,
  input  tpcp_pkg::cfg_t    cfg,
  input  logic              pop,
  output logic              push,
  output tpcp_pkg::q_item_t push_data
);

  logic                           in_acc;
  logic [tpcp_pkg::Q_CW-1:0]      inflight_r, inflight_nxt;
  logic [tpcp_pkg::COUNT_W-1:0]   in_duty [tpcp_pkg::NPHASE];

  logic                           s1_valid_r, s2_valid_r, s3_valid_r;
  tpcp_pkg::ctl_t                 s1_ctl_r, s2_ctl_r, s3_ctl_r, s1_ctl_nxt;
  logic [tpcp_pkg::SCALED_W-1:0]  s1_x_r   [tpcp_pkg::NPHASE];
  logic [tpcp_pkg::SCALED_W-1:0]  s1_x_nxt [tpcp_pkg::NPHASE];
  logic [tpcp_pkg::COUNT_W-1:0]   s2_d_r   [tpcp_pkg::NPHASE];
  logic [tpcp_pkg::COUNT_W-1:0]   s2_d_nxt [tpcp_pkg::NPHASE];
  logic                           s3_zero_r   [tpcp_pkg::NPHASE];
  logic                           s3_zero_nxt [tpcp_pkg::NPHASE];
  logic [tpcp_pkg::COUNT_W-1:0]   s3_ca_r     [tpcp_pkg::NPHASE];
  logic [tpcp_pkg::COUNT_W-1:0]   s3_ca_nxt   [tpcp_pkg::NPHASE];
  logic [tpcp_pkg::COUNT_W:0]     s3_cb_r     [tpcp_pkg::NPHASE];
  logic [tpcp_pkg::COUNT_W:0]     s3_cb_nxt   [tpcp_pkg::NPHASE];

  logic [tpcp_pkg::COUNT_W-1:0]   centre, lim, top1;

  // Credit count: ticks in the pipeline plus ticks in the queue
  assign in_stall = (inflight_r == tpcp_pkg::Q_CW'(tpcp_pkg::Q_DEPTH));
  assign in_acc   = in_valid && !in_stall;

  always_comb begin
    inflight_nxt = inflight_r + tpcp_pkg::Q_CW'(in_acc) - tpcp_pkg::Q_CW'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inflight_r <= '0;
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
      s3_valid_r <= 1'b0;
    end else begin
      inflight_r <= inflight_nxt;
      s1_valid_r <= in_acc;
      s2_valid_r <= s1_valid_r;
      s3_valid_r <= s2_valid_r;
    end
  end

  assign in_duty[0] = in_data.duty_u;
  assign in_duty[1] = in_data.duty_v;
  assign in_duty[2] = in_data.duty_w;

  // Shared period-derived values
  assign centre = cfg.period_counts >> 1;
  assign lim    = (cfg.period_counts >= tpcp_pkg::COUNT_W'(2)) ?
                  cfg.period_counts - tpcp_pkg::COUNT_W'(2) : '0;
  assign top1   = (cfg.period_counts >= tpcp_pkg::COUNT_W'(1)) ?
                  cfg.period_counts - tpcp_pkg::COUNT_W'(1) : '0;

  // Stage 1: permille clamp and period multiply (counts mode passes the duty through)
  always_comb begin
    logic [tpcp_pkg::PERMILLE_W-1:0] pm;
    s1_ctl_nxt.duty_write     = in_data.duty_write;
    s1_ctl_nxt.outputs_enable = in_data.outputs_enable;
    s1_ctl_nxt.gate_enable    = in_data.gate_enable;
    for (int i = 0; i < tpcp_pkg::NPHASE; i++) begin
      pm = (in_duty[i] > tpcp_pkg::COUNT_W'(tpcp_pkg::PERMILLE_MAX)) ?
           tpcp_pkg::PERMILLE_MAX : in_duty[i][tpcp_pkg::PERMILLE_W-1:0];
      if (cfg.permille_mode) begin
        s1_x_nxt[i] = tpcp_pkg::SCALED_W'(cfg.period_counts) *
                      tpcp_pkg::SCALED_W'(pm);
      end else begin
        s1_x_nxt[i] = tpcp_pkg::SCALED_W'(in_duty[i]);
      end
    end
  end

  // Stage 2: divide by 1000 through the reciprocal (counts mode passes the duty through)
  always_comb begin
    logic [tpcp_pkg::RPROD_W-1:0] rp;
    for (int i = 0; i < tpcp_pkg::NPHASE; i++) begin
      rp = tpcp_pkg::RPROD_W'(s1_x_r[i]) * tpcp_pkg::RPROD_W'(tpcp_pkg::RECIP_1000);
      if (cfg.permille_mode) begin
        s2_d_nxt[i] = rp[tpcp_pkg::RECIP_SHIFT +: tpcp_pkg::COUNT_W];
      end else begin
        s2_d_nxt[i] = s1_x_r[i][tpcp_pkg::COUNT_W-1:0];
      end
    end
  end

  // Stage 3: clamp the duty and place the raw edges around the centre
  always_comb begin
    logic [tpcp_pkg::COUNT_W-1:0] dc, half;
    for (int i = 0; i < tpcp_pkg::NPHASE; i++) begin
      dc             = (s2_d_r[i] > lim) ? lim : s2_d_r[i];
      half           = dc >> 1;
      s3_zero_nxt[i] = (s2_d_r[i] == '0);
      s3_ca_nxt[i]   = (half <= centre) ? centre - half : '0;
      s3_cb_nxt[i]   = {1'b0, centre} + {1'b0, half};
    end
  end

  always_ff @(posedge clk) begin
    s1_ctl_r <= s1_ctl_nxt;
    s2_ctl_r <= s1_ctl_r;
    s3_ctl_r <= s2_ctl_r;
    for (int i = 0; i < tpcp_pkg::NPHASE; i++) begin
      s1_x_r[i]    <= s1_x_nxt[i];
      s2_d_r[i]    <= s2_d_nxt[i];
      s3_zero_r[i] <= s3_zero_nxt[i];
      s3_ca_r[i]   <= s3_ca_nxt[i];
      s3_cb_r[i]   <= s3_cb_nxt[i];
    end
  end

  // Final limits on the way into the queue
  always_comb begin
    logic [tpcp_pkg::COUNT_W-1:0] ca;
    logic [tpcp_pkg::COUNT_W:0]   cb1;
    push_data.ctl = s3_ctl_r;
    for (int i = 0; i < tpcp_pkg::NPHASE; i++) begin
      ca  = (s3_ca_r[i] < cfg.min_compare) ? cfg.min_compare : s3_ca_r[i];
      cb1 = (s3_cb_r[i] > {1'b0, top1}) ? {1'b0, top1} : s3_cb_r[i];
      if (s3_zero_r[i]) begin
        push_data.edges[i].zero = 1'b1;
        push_data.edges[i].ca   = centre;
        push_data.edges[i].cb   = {1'b0, centre} + (tpcp_pkg::COUNT_W+1)'(1);
      end else begin
        push_data.edges[i].zero = 1'b0;
        push_data.edges[i].ca   = ca;
        push_data.edges[i].cb   = (cb1 <= {1'b0, ca}) ?
                                  {1'b0, ca} + (tpcp_pkg::COUNT_W+1)'(1) : cb1;
      end
    end
  end

  assign push = s3_valid_r;

endmodule

>>> rtl/core/tpcp_queue.sv
module tpcp_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  tpcp_pkg::q_item_t push_data,
  input  logic              pop,
  output logic              head_valid,
  output tpcp_pkg::q_item_t head_data
);

  tpcp_pkg::q_item_t          mem_r [tpcp_pkg::Q_DEPTH];
  logic [tpcp_pkg::Q_AW-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [tpcp_pkg::Q_AW-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [tpcp_pkg::Q_CW-1:0]  count_r, count_nxt;

  // Pointer and fill bookkeeping; the front's credits keep it from overflowing
  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + tpcp_pkg::Q_AW'(1) : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + tpcp_pkg::Q_AW'(1) : rd_ptr_r;
    count_nxt  = count_r + tpcp_pkg::Q_CW'(push) - tpcp_pkg::Q_CW'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  assign head_valid = (count_r != '0);
  assign head_data  = mem_r[rd_ptr_r];

endmodule

>>> rtl/core/tpcp_back.sv
module tpcp_back (
  input  logic               clk,
  input  logic               rst_n,
  input  tpcp_pkg::cfg_t     cfg,
  input  logic               head_valid,
  input  tpcp_pkg::q_item_t  head_data,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_stall,
  output tpcp_pkg::out_item_t out_data
);

  logic                          fire;
  logic [tpcp_pkg::COUNT_W-1:0]  count_r, count_nxt;
  tpcp_pkg::edge_t               pend_r [tpcp_pkg::NPHASE];
  tpcp_pkg::edge_t               pend_nxt [tpcp_pkg::NPHASE];
  tpcp_pkg::edge_t               live_r [tpcp_pkg::NPHASE];
  tpcp_pkg::edge_t               live_nxt [tpcp_pkg::NPHASE];
  logic                          ref_r [tpcp_pkg::NPHASE];
  logic                          ref_nxt [tpcp_pkg::NPHASE];
  logic [tpcp_pkg::DEAD_W-1:0]   dead_r [tpcp_pkg::NPHASE];
  logic [tpcp_pkg::DEAD_W-1:0]   dead_nxt [tpcp_pkg::NPHASE];
  logic                          lo [tpcp_pkg::NPHASE];
  logic                          hi [tpcp_pkg::NPHASE];
  logic                          wrap;
  logic [tpcp_pkg::COUNT_W-1:0]  top1, trig_lo, trig;
  logic                          out_valid_r, out_valid_nxt;
  tpcp_pkg::out_item_t           out_data_r, out_data_nxt;

  // Take a tick whenever the output register is free or being emptied
  assign fire = head_valid && (!out_valid_r || !out_stall);
  assign pop  = fire;

  assign wrap = (count_r >= cfg.period_counts);
  assign top1 = (cfg.period_counts >= tpcp_pkg::COUNT_W'(1)) ?
                cfg.period_counts - tpcp_pkg::COUNT_W'(1) : '0;

  // Trigger point: raise to the minimum compare, then the period bound wins
  assign trig_lo = (cfg.adc_point < cfg.min_compare) ? cfg.min_compare : cfg.adc_point;
  assign trig    = (trig_lo > top1) ? top1 : trig_lo;

  // Per-phase reference, dead time and edge reload
  always_comb begin
    logic                        nref;
    logic [tpcp_pkg::DEAD_W-1:0] t;
    for (int i = 0; i < tpcp_pkg::NPHASE; i++) begin
      nref = ref_r[i];
      if (live_r[i].zero) begin
        if (wrap) begin
          nref = 1'b1;
        end
      end else begin
        if (count_r == live_r[i].ca) begin
          nref = 1'b0;
        end
        if ({1'b0, count_r} == live_r[i].cb) begin
          nref = 1'b1;
        end
      end
      t = dead_r[i];
      if (nref != ref_r[i]) begin
        t = nref ? cfg.dead_rise : cfg.dead_fall;
      end
      if (t != '0) begin
        lo[i]       = 1'b0;
        hi[i]       = 1'b0;
        dead_nxt[i] = t - tpcp_pkg::DEAD_W'(1);
      end else begin
        lo[i]       = nref;
        hi[i]       = !nref;
        dead_nxt[i] = t;
      end
      ref_nxt[i]  = nref;
      pend_nxt[i] = head_data.ctl.duty_write ? head_data.edges[i] : pend_r[i];
      live_nxt[i] = wrap ? pend_nxt[i] : live_r[i];
    end
  end

  assign count_nxt = wrap ? '0 : count_r + tpcp_pkg::COUNT_W'(1);

  // Result of this tick
  always_comb begin
    logic oe;
    oe = head_data.ctl.outputs_enable;
    out_data_nxt.u_low_gate    = oe && lo[0];
    out_data_nxt.u_high_gate   = oe && hi[0];
    out_data_nxt.v_low_gate    = oe && lo[1];
    out_data_nxt.v_high_gate   = oe && hi[1];
    out_data_nxt.w_low_gate    = oe && lo[2];
    out_data_nxt.w_high_gate   = oe && hi[2];
    out_data_nxt.driver_enable = head_data.ctl.gate_enable;
    out_data_nxt.adc_trigger   = (count_r == trig);
    out_data_nxt.period_event  = wrap;
    out_data_nxt.count_now     = count_r;
  end

  always_comb begin
    if (fire) begin
      out_valid_nxt = 1'b1;
    end else begin
      out_valid_nxt = out_valid_r && out_stall;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < tpcp_pkg::NPHASE; i++) begin
        pend_r[i] <= tpcp_pkg::RESET_EDGE;
        live_r[i] <= tpcp_pkg::RESET_EDGE;
        ref_r[i]  <= 1'b1;
        dead_r[i] <= '0;
      end
    end else begin
      out_valid_r <= out_valid_nxt;
      if (fire) begin
        count_r <= count_nxt;
        for (int i = 0; i < tpcp_pkg::NPHASE; i++) begin
          pend_r[i] <= pend_nxt[i];
          live_r[i] <= live_nxt[i];
          ref_r[i]  <= ref_nxt[i];
          dead_r[i] <= dead_nxt[i];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

>>> rtl/core/three_phase_centred_pwm.sv
// Three-phase centre-aligned PWM with complementary gates and dead time. Each
// input transaction is one counter tick and yields one result transaction with
// the six gate levels, driver enable, ADC trigger, period event and the counter
// value. The block sustains one tick per clock cycle while the output is not stalled: a
// three-stage front end (permille multiply, reciprocal divide by 1000, edge placement)
// feeds an eight-entry queue, and the back end advances the counter and the three
// reference/dead-time trackers by one tick per cycle into an output register. A
// result passes through the three front stage registers, the queue and the output
// register. Duty writes go live on the next wrap tick (at once if the write
// arrives on a wrap tick). Configuration is written through cfg_we, cfg_index
// and cfg_wdata and must only change while no ticks are in flight.
module three_phase_centred_pwm (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  tpcp_pkg::in_item_t                  in_data,
  output logic                                out_valid,
  input  logic                                out_stall,
  output tpcp_pkg::out_item_t                 out_data,
  input  logic                                cfg_we,
  input  logic [tpcp_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [tpcp_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

  tpcp_pkg::cfg_t    cfg_r, cfg_nxt;
  logic              push, pop, head_valid;
  tpcp_pkg::q_item_t push_data, head_data;

  // Configuration register decode; unknown indexes are ignored
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        tpcp_pkg::REG_PERIOD:    cfg_nxt.period_counts = cfg_wdata;
        tpcp_pkg::REG_MIN_CMP:   cfg_nxt.min_compare   = cfg_wdata;
        tpcp_pkg::REG_DEAD_RISE: cfg_nxt.dead_rise     = cfg_wdata[tpcp_pkg::DEAD_W-1:0];
        tpcp_pkg::REG_DEAD_FALL: cfg_nxt.dead_fall     = cfg_wdata[tpcp_pkg::DEAD_W-1:0];
        tpcp_pkg::REG_ADC_POINT: cfg_nxt.adc_point     = cfg_wdata;
        tpcp_pkg::REG_PERMILLE:  cfg_nxt.permille_mode = cfg_wdata[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.period_counts <= tpcp_pkg::PERIOD_RESET;
      cfg_r.min_compare   <= tpcp_pkg::MIN_CMP_RESET;
      cfg_r.dead_rise     <= '0;
      cfg_r.dead_fall     <= '0;
      cfg_r.adc_point     <= tpcp_pkg::ADC_RESET;
      cfg_r.permille_mode <= 1'b0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // Front end: accept ticks and compute edge sets
  tpcp_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .cfg       (cfg_r),
    .pop       (pop),
    .push      (push),
    .push_data (push_data)
  );

  // Queue between front and back
  tpcp_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_data  (push_data),
    .pop        (pop),
    .head_valid (head_valid),
    .head_data  (head_data)
  );

  // Back end: counter, references, dead time and output register
  tpcp_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .head_valid (head_valid),
    .head_data  (head_data),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data)
  );

endmodule

>>> sim/tb.sv
`timescale 1ns / 1ps

module tb;

  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_CYCLES = 60;
  localparam int DRAIN_CYCLES = 10;
  localparam logic [tpcp_pkg::CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

  // Edge pair of one phase as the predictor keeps it
  typedef struct packed {
    bit        zero;
    bit [31:0] ca;
    bit [31:0] cb;
  } phase_edges_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  tpcp_pkg::in_item_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  tpcp_pkg::out_item_t out_data;
  logic cfg_we = 1'b0;
  logic [tpcp_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [tpcp_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;

  // Predictor state and its copy of the registers
  bit [31:0] cfg_period, cfg_min_cmp, cfg_dead_rise, cfg_dead_fall, cfg_adc;
  bit cfg_permille;
  bit [31:0] tick_cnt;
  phase_edges_t pend_edges[3];
  phase_edges_t live_edges[3];
  bit ref_lvl[3];
  bit [8:0] dead_left[3];

  tpcp_pkg::out_item_t expected_ticks[$];
  int errors = 0;
  int cycles = 0;
  int sender_idle_pct = 0;
  int stall_pct = 0;
  int hold_requests = 0;
  int holds_taken = 0;
  int hold_left = 0;

  three_phase_centred_pwm u_dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  always #5 clk = ~clk;

  // Run limit
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Receiver: random stalls, plus long hold-offs on request
  always @(posedge clk) begin
    if (holds_taken != hold_requests) begin
      holds_taken++;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // Compare place for duty -> edge pair
  function automatic phase_edges_t edges_for_duty(bit [31:0] duty);
    phase_edges_t e;
    bit [31:0] p, centre, half, lim, top1;
    p = cfg_period;
    centre = p / 2;
    if (cfg_permille) begin
      if (duty > 1000) duty = 1000;
      duty = (p * duty) / 1000;
    end
    if (duty == 0) begin
      e.zero = 1'b1;
      e.ca = centre;
      e.cb = centre + 1;
      return e;
    end
    lim = (p >= 2) ? p - 2 : 0;
    top1 = (p >= 1) ? p - 1 : 0;
    if (duty > lim) duty = lim;
    half = duty / 2;
    e.zero = 1'b0;
    e.ca = (half <= centre) ? centre - half : 0;
    e.cb = centre + half;
    if (e.ca < cfg_min_cmp) e.ca = cfg_min_cmp;
    if (e.cb > top1) e.cb = top1;
    if (e.cb <= e.ca) e.cb = e.ca + 1;
    return e;
  endfunction

  task automatic pwm_reset_state();
    cfg_period = 1000;
    cfg_min_cmp = 3;
    cfg_dead_rise = 0;
    cfg_dead_fall = 0;
    cfg_adc = 900;
    cfg_permille = 1'b0;
    tick_cnt = 0;
    for (int i = 0; i < 3; i++) begin
      pend_edges[i] = edges_for_duty(0);
      live_edges[i] = pend_edges[i];
      ref_lvl[i] = 1'b1;
      dead_left[i] = '0;
    end
  endtask

  // One counter tick of the expected behaviour
  function automatic tpcp_pkg::out_item_t pwm_tick(tpcp_pkg::in_item_t t);
    tpcp_pkg::out_item_t o;
    bit [15:0] duty[3];
    bit lo_g[3];
    bit hi_g[3];
    bit [31:0] cnt, trig, top1;
    bit wrap, nlvl;
    duty[0] = t.duty_u;
    duty[1] = t.duty_v;
    duty[2] = t.duty_w;
    cnt = tick_cnt & 32'hFFFF;
    wrap = (cnt >= cfg_period);
    if (t.duty_write) begin
      for (int i = 0; i < 3; i++) pend_edges[i] = edges_for_duty(32'(duty[i]));
    end
    for (int i = 0; i < 3; i++) begin
      nlvl = ref_lvl[i];
      if (live_edges[i].zero) begin
        if (wrap) nlvl = 1'b1;
      end else begin
        if (cnt == live_edges[i].ca) nlvl = 1'b0;
        if (cnt == live_edges[i].cb) nlvl = 1'b1;
      end
      if (nlvl != ref_lvl[i]) dead_left[i] = nlvl ? cfg_dead_rise[8:0] : cfg_dead_fall[8:0];
      ref_lvl[i] = nlvl;
      if (dead_left[i] != 0) begin
        lo_g[i] = 1'b0;
        hi_g[i] = 1'b0;
        dead_left[i] = dead_left[i] - 9'd1;
      end else begin
        lo_g[i] = nlvl;
        hi_g[i] = ~nlvl;
      end
      lo_g[i] = lo_g[i] & t.outputs_enable;
      hi_g[i] = hi_g[i] & t.outputs_enable;
    end
    // Trigger point: raise to the minimum, then the period bound wins
    trig = cfg_adc;
    top1 = (cfg_period >= 1) ? cfg_period - 1 : 0;
    if (trig < cfg_min_cmp) trig = cfg_min_cmp;
    if (trig > top1) trig = top1;
    o.u_low_gate = lo_g[0];
    o.u_high_gate = hi_g[0];
    o.v_low_gate = lo_g[1];
    o.v_high_gate = hi_g[1];
    o.w_low_gate = lo_g[2];
    o.w_high_gate = hi_g[2];
    o.driver_enable = t.gate_enable;
    o.adc_trigger = (cnt == trig);
    o.period_event = wrap;
    o.count_now = cnt[15:0];
    if (wrap) begin
      for (int i = 0; i < 3; i++) live_edges[i] = pend_edges[i];
      tick_cnt = 0;
    end else begin
      tick_cnt = (cnt + 1) & 32'hFFFF;
    end
    return o;
  endfunction

  task automatic report_mismatch(string name, int unsigned exp_v, int unsigned got_v);
    $display("%0t tb: mismatch on %s expected %0d actual %0d", $time, name, exp_v, got_v);
    errors++;
  endtask

  // Result checker
  always @(posedge clk) begin
    tpcp_pkg::out_item_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_ticks.size() == 0) begin
        $display("%0t tb: unexpected result transaction, expected none actual %h",
                 $time, out_data);
        errors++;
      end else begin
        e = expected_ticks.pop_front();
        if (out_data.u_low_gate !== e.u_low_gate)
          report_mismatch("u_low_gate", e.u_low_gate, out_data.u_low_gate);
        if (out_data.u_high_gate !== e.u_high_gate)
          report_mismatch("u_high_gate", e.u_high_gate, out_data.u_high_gate);
        if (out_data.v_low_gate !== e.v_low_gate)
          report_mismatch("v_low_gate", e.v_low_gate, out_data.v_low_gate);
        if (out_data.v_high_gate !== e.v_high_gate)
          report_mismatch("v_high_gate", e.v_high_gate, out_data.v_high_gate);
        if (out_data.w_low_gate !== e.w_low_gate)
          report_mismatch("w_low_gate", e.w_low_gate, out_data.w_low_gate);
        if (out_data.w_high_gate !== e.w_high_gate)
          report_mismatch("w_high_gate", e.w_high_gate, out_data.w_high_gate);
        if (out_data.driver_enable !== e.driver_enable)
          report_mismatch("driver_enable", e.driver_enable, out_data.driver_enable);
        if (out_data.adc_trigger !== e.adc_trigger)
          report_mismatch("adc_trigger", e.adc_trigger, out_data.adc_trigger);
        if (out_data.period_event !== e.period_event)
          report_mismatch("period_event", e.period_event, out_data.period_event);
        if (out_data.count_now !== e.count_now)
          report_mismatch("count_now", e.count_now, out_data.count_now);
      end
    end
  end

  // Send one tick; prediction happens at acceptance
  task automatic send_tick(tpcp_pkg::in_item_t t);
    int gap;
    gap = 0;
    while (gap < 6 && $urandom_range(99) < sender_idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= t;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    expected_ticks.push_back(pwm_tick(t));
  endtask

  function automatic tpcp_pkg::in_item_t mk_tick(bit wr, bit [15:0] u, bit [15:0] v,
                                                 bit [15:0] w, bit oe, bit ge);
    tpcp_pkg::in_item_t t;
    t.duty_u = u;
    t.duty_v = v;
    t.duty_w = w;
    t.duty_write = wr;
    t.outputs_enable = oe;
    t.gate_enable = ge;
    return t;
  endfunction

  // Block idle: input lowered, all results back, pipeline settled
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (expected_ticks.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [tpcp_pkg::CFG_IDX_W-1:0] idx,
                           logic [tpcp_pkg::CFG_DATA_W-1:0] value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    case (idx)
      tpcp_pkg::REG_PERIOD:    cfg_period = 32'(value);
      tpcp_pkg::REG_MIN_CMP:   cfg_min_cmp = 32'(value);
      tpcp_pkg::REG_DEAD_RISE: cfg_dead_rise = 32'(value & 16'h01FF);
      tpcp_pkg::REG_DEAD_FALL: cfg_dead_fall = 32'(value & 16'h01FF);
      tpcp_pkg::REG_ADC_POINT: cfg_adc = 32'(value);
      tpcp_pkg::REG_PERMILLE:  cfg_permille = value[0];
      default: ;
    endcase
  endtask

  task automatic set_config(bit [15:0] period, bit [15:0] min_cmp, bit [15:0] rise,
                            bit [15:0] fall, bit [15:0] adc, bit [15:0] permille);
    wait_drained();
    write_reg(tpcp_pkg::REG_PERIOD, period);
    write_reg(tpcp_pkg::REG_MIN_CMP, min_cmp);
    write_reg(tpcp_pkg::REG_DEAD_RISE, rise);
    write_reg(tpcp_pkg::REG_DEAD_FALL, fall);
    write_reg(tpcp_pkg::REG_ADC_POINT, adc);
    write_reg(tpcp_pkg::REG_PERMILLE, permille);
  endtask

  // Duty spread: zero, top, near the period, permille range, full width
  function automatic bit [15:0] rand_duty();
    case ($urandom_range(9))
      0: return 16'd0;
      1: return 16'hFFFF;
      2, 3, 4, 5: return 16'($urandom_range(0, cfg_period + 2));
      6, 7: return 16'($urandom_range(0, 1100));
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic tpcp_pkg::in_item_t random_tick();
    return mk_tick($urandom_range(99) < 15, rand_duty(), rand_duty(), rand_duty(),
                   $urandom_range(99) < 90, 1'($urandom_range(1)));
  endfunction

  // Counts mode: zero duty, clamped duty, narrow pulses, dead times, gates off
  task automatic test_counts_duties();
    set_config(10, 0, 1, 2, 16'hFFFF, 0);
    send_tick(mk_tick(1, 0, 16'hFFFF, 3, 1, 1));
    for (int i = 0; i < 6; i++) send_tick(mk_tick(0, 0, 0, 0, 1, i[0]));
    send_tick(mk_tick(1, 1, 6, 2, 1, 0));
    for (int i = 0; i < 6; i++) send_tick(mk_tick(0, 16'h5555, 16'hAAAA, 0, i > 3, 1));
  endtask

  // Permille mode: top clamp, over-range, duty that scales to zero
  task automatic test_permille_duties();
    set_config(20, 3, 16'hFFFF, 0, 0, 16'hFFFF);
    send_tick(mk_tick(1, 1000, 16'hFFFF, 1, 1, 1));
    for (int i = 0; i < 7; i++) send_tick(mk_tick(0, 0, 0, 0, 1, 1));
  endtask

  // Zero and unit period, top period, then period dropped under the count
  task automatic test_period_corners();
    set_config(0, 0, 0, 0, 0, 0);
    send_tick(mk_tick(1, 5, 0, 16'hFFFF, 1, 1));
    send_tick(mk_tick(0, 0, 0, 0, 1, 0));
    wait_drained();
    write_reg(tpcp_pkg::REG_PERIOD, 1);
    send_tick(mk_tick(1, 1, 2, 0, 1, 1));
    send_tick(mk_tick(0, 0, 0, 0, 1, 1));
    wait_drained();
    write_reg(tpcp_pkg::REG_PERIOD, 16'hFFFF);
    for (int i = 0; i < 7; i++) send_tick(mk_tick(i == 0, 100, 16'hFFFF, 0, 1, 1));
    wait_drained();
    write_reg(tpcp_pkg::REG_PERIOD, 4);
    for (int i = 0; i < 3; i++) send_tick(mk_tick(0, 0, 0, 0, 1, 1));
  endtask

  // Writes to an unused register index leave the block unchanged
  task automatic test_unused_register();
    wait_drained();
    write_reg(REG_UNUSED, 16'hFFFF);
    for (int i = 0; i < 4; i++) send_tick(mk_tick(0, 0, 0, 0, 1, 1));
  endtask

  task automatic test_random_phase(bit [15:0] period, bit [15:0] min_cmp, bit [15:0] rise,
                                   bit [15:0] fall, bit [15:0] adc, bit [15:0] permille,
                                   int n_ticks, bit hold);
    set_config(period, min_cmp, rise, fall, adc, permille);
    // First transaction always loads duties so the phase starts well defined
    send_tick(mk_tick(1, rand_duty(), rand_duty(), rand_duty(), 1, 1));
    if (hold) hold_requests++;
    for (int i = 0; i < n_ticks; i++) send_tick(random_tick());
  endtask

  initial begin
    pwm_reset_state();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    sender_idle_pct = 36;
    stall_pct = 48;
    test_counts_duties();
    test_permille_duties();
    test_period_corners();
    test_unused_register();
    test_random_phase(40, 3, 0, 0, 20, 0, 250, 1'b0);
    test_random_phase(64, 0, 16'hFFFF, 511, 0, 1, 250, 1'b1);

    sender_idle_pct = 48;
    stall_pct = 36;
    test_random_phase(25, 16'hFFFF, 5, 1, 16'hFFFF, 0, 250, 1'b0);
    test_random_phase(100, 10, 3, 7, 50, 1, 250, 1'b1);

    sender_idle_pct = 0;
    stall_pct = 0;
    test_random_phase(4, 1, 1, 0, 2, 0, 200, 1'b0);
    test_random_phase(16'hFFFF, 0, 2, 2, 100, 0, 50, 1'b0);
    test_random_phase(30, 2, 4, 3, 29, 1, 250, 1'b1);

    wait_drained();
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/core/tpcp_pkg.sv
rtl/core/tpcp_front.sv
rtl/core/tpcp_queue.sv
rtl/core/tpcp_back.sv
rtl/core/three_phase_centred_pwm.sv
sim/tb.sv
